// ===== rtl/ssd_pkg.sv =====
// ----------------------------------------------------------------------------
// ssd_pkg
// Types and constants shared by the sensor settling detector.
// ----------------------------------------------------------------------------
package ssd_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int SUM_W     = 16;
    localparam int TIME_W    = 16;
    localparam int SPREAD_W  = 12;
    localparam int OP_W      = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [OP_W-1:0] OP_START  = 2'd0;
    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

    localparam logic STATUS_SETTLED = 1'b0;
    localparam logic STATUS_TIMEOUT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPREAD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS = 2'd1;

    localparam logic [SPREAD_W-1:0] MAX_SPREAD_RST = 12'd5;
    localparam logic [TIME_W-1:0]   TIMEOUT_MS_RST = 16'd500;
    localparam logic [TIME_W-1:0]   TIME_MAX       = 16'hFFFF;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [SAMPLE_W-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic                status;
        logic [SAMPLE_W-1:0] mean_value;
        logic [TIME_W-1:0]   settle_time_ms;
    } out_item_t;

endpackage

// ===== rtl/sensor_settling_detector.sv =====
// ----------------------------------------------------------------------------
// sensor_settling_detector
// Groups sensor samples, checks group spread and reports settle or timeout.
// ----------------------------------------------------------------------------
// One transaction is taken per clock while no waiting result stalls it. An
// accepted transaction is held in the input register; when it advances, the
// group state is updated and, when a group ends the session, the result
// register is loaded and raises out_valid. The single stage between input and
// result register holds the compare, 16-bit add and a constant-multiply for
// the mean. A waiting result stalls only the transaction that would produce
// the next result. Configuration writes are always taken (cfg_ready is tied
// high).
module sensor_settling_detector
    import ssd_pkg::*;
#(
    parameter int GROUP_SIZE = 5
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CNT_W     = $clog2(GROUP_SIZE);
    localparam int DIV_SHIFT = SUM_W + $clog2(GROUP_SIZE);
    localparam int PROD_W    = SUM_W + DIV_SHIFT;
    localparam logic [DIV_SHIFT-1:0] DIV_MULT =
        DIV_SHIFT'((2 ** DIV_SHIFT + GROUP_SIZE - 1) / GROUP_SIZE);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GROUP_SIZE - 1);

    logic                in_valid_reg;
    in_item_t            in_item_reg;
    logic                out_valid_reg;
    out_item_t           out_item_reg;
    out_item_t           out_item_next;

    logic [SPREAD_W-1:0] max_spread_reg;
    logic [TIME_W-1:0]   timeout_ms_reg;

    logic [CNT_W-1:0]    count_reg, count_next;
    logic [SAMPLE_W-1:0] min_reg, min_next;
    logic [SAMPLE_W-1:0] max_reg, max_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [TIME_W-1:0]   elapsed_reg, elapsed_next;
    logic                active_reg, active_next;

    logic                first;
    logic                last;
    logic [SPREAD_W-1:0] spread;
    logic [PROD_W-1:0]   prod;
    logic                settled;
    logic                timed_out;
    logic                has_result;
    logic                advance;
    logic                out_load;

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    assign advance  = in_valid_reg && (!has_result || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign out_load = advance && has_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_spread_reg <= MAX_SPREAD_RST;
            timeout_ms_reg <= TIMEOUT_MS_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_MAX_SPREAD)
            begin
                max_spread_reg <= cfg_data[SPREAD_W-1:0];
            end
            else if (cfg_index == CFG_TIMEOUT_MS)
            begin
                timeout_ms_reg <= cfg_data[TIME_W-1:0];
            end
        end
    end

    // group arithmetic on the registered transaction
    always_comb
    begin
        first    = (count_reg == '0);
        min_next = (first || in_item_reg.sample < min_reg) ? in_item_reg.sample : min_reg;
        max_next = (first || in_item_reg.sample > max_reg) ? in_item_reg.sample : max_reg;
        sum_next = first ? SUM_W'(in_item_reg.sample)
                         : sum_reg + SUM_W'(in_item_reg.sample);
        last      = (count_reg == CNT_LAST);
        spread    = max_next - min_next;
        prod      = PROD_W'(sum_next) * PROD_W'(DIV_MULT);
        settled   = (spread < max_spread_reg);
        timed_out = (elapsed_reg > timeout_ms_reg);

        out_item_next.status         = settled ? STATUS_SETTLED : STATUS_TIMEOUT;
        out_item_next.mean_value     = prod[DIV_SHIFT +: SAMPLE_W];
        out_item_next.settle_time_ms = settled ? elapsed_reg : timeout_ms_reg;

        count_next   = count_reg;
        elapsed_next = elapsed_reg;
        active_next  = active_reg;
        has_result   = 1'b0;

        case (in_item_reg.op)
            OP_START:
            begin
                count_next   = '0;
                elapsed_next = '0;
                active_next  = 1'b1;
            end
            OP_SAMPLE:
            begin
                if (active_reg)
                begin
                    if (last)
                    begin
                        count_next = '0;
                        if (settled || timed_out)
                        begin
                            has_result  = 1'b1;
                            active_next = 1'b0;
                        end
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            OP_TICK:
            begin
                if (active_reg && elapsed_reg != TIME_MAX)
                begin
                    elapsed_next = elapsed_reg + TIME_W'(1);
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            elapsed_reg   <= '0;
            active_reg    <= 1'b1;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                count_reg   <= count_next;
                elapsed_reg <= elapsed_next;
                active_reg  <= active_next;
            end
        end
    end

    // payload registers; group min/max/sum are reseeded by each first sample
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_item_reg <= in_data;
        end
        if (out_load)
        begin
            out_item_reg <= out_item_next;
        end
        if (advance && in_item_reg.op == OP_SAMPLE && active_reg)
        begin
            min_reg <= min_next;
            max_reg <= max_next;
            sum_reg <= sum_next;
        end
    end

`ifndef SYNTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_LAST)
        else $error("group count out of range");

    a_result_ends_session: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> !active_reg)
        else $error("session still active after result");

    a_session_end_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(active_reg) |-> $past(out_load))
        else $error("session ended without result");

    a_result_hold_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && has_result && out_valid_reg && !out_ready |=> in_valid_reg)
        else $error("result-producing transaction dropped while output full");

    a_elapsed_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_item_reg.op == OP_TICK && elapsed_reg == TIME_MAX
        |=> elapsed_reg == TIME_MAX)
        else $error("elapsed counter wrapped");
`endif

endmodule

// ===== bench/sensor_settling_detector_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sensor_settling_detector_test
// Self-checking bench for the sensor settling detector. A queue-fed driver
// sends start, sample and tick transactions under random valid/ready idling.
// A monitor runs a local settle/timeout predictor on each accepted
// transaction and compares every result field by field. Directed cases cover
// field and register extremes and ignored ops. Random sessions of sample
// groups with mixed spread follow, over several register settings.
// ----------------------------------------------------------------------------
module sensor_settling_detector_test;
    import ssd_pkg::*;

    localparam int GROUP_N      = 5;
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASE_ITEMS  = 480;
    localparam int CHUNK_ITEMS  = 115;

    localparam logic [OP_W-1:0]      OP_UNUSED   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    in_item_t  pending_items[$];
    out_item_t expected_reports[$];

    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    int spread_choice     = int'(MAX_SPREAD_RST);

    int pushed_count = 0;
    int accepted_count = 0;
    int effective_count = 0;
    int settled_count = 0;
    int timeout_count = 0;
    int cfg_count = 0;
    int error_count = 0;

    // predictor state
    logic [SPREAD_W-1:0] spread_limit  = MAX_SPREAD_RST;
    logic [TIME_W-1:0]   timeout_limit = TIMEOUT_MS_RST;
    int                  group_fill    = 0;
    logic [SAMPLE_W-1:0] group_lo      = '0;
    logic [SAMPLE_W-1:0] group_hi      = '0;
    logic [SUM_W-1:0]    group_sum     = '0;
    logic [TIME_W-1:0]   elapsed       = '0;
    logic                running       = 1'b1;

    sensor_settling_detector #(
        .GROUP_SIZE(GROUP_N)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic apply_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] value);
        if (idx == CFG_MAX_SPREAD)
            spread_limit = value[SPREAD_W-1:0];
        else if (idx == CFG_TIMEOUT_MS)
            timeout_limit = value[TIME_W-1:0];
    endtask

    task automatic clear_group();
        group_fill = 0;
        group_lo   = '0;
        group_hi   = '0;
        group_sum  = '0;
    endtask

    task automatic advance_session(input in_item_t item, output bit effective,
                                   output bit produced, output out_item_t report);
        logic [SAMPLE_W-1:0] spread;
        logic [SAMPLE_W-1:0] mean;
        effective = 1'b0;
        produced  = 1'b0;
        report    = '0;
        if (item.op == OP_START)
        begin
            clear_group();
            elapsed   = '0;
            running   = 1'b1;
            effective = 1'b1;
        end
        else if (running && item.op == OP_TICK)
        begin
            effective = 1'b1;
            if (elapsed != TIME_MAX)
                elapsed = elapsed + TIME_W'(1);
        end
        else if (running && item.op == OP_SAMPLE)
        begin
            effective = 1'b1;
            if (group_fill == 0)
            begin
                group_lo  = item.sample;
                group_hi  = item.sample;
                group_sum = SUM_W'(item.sample);
            end
            else
            begin
                if (item.sample < group_lo)
                    group_lo = item.sample;
                if (item.sample > group_hi)
                    group_hi = item.sample;
                group_sum = group_sum + SUM_W'(item.sample);
            end
            if (group_fill + 1 < GROUP_N)
                group_fill = group_fill + 1;
            else
            begin
                mean   = SAMPLE_W'(group_sum / GROUP_N);
                spread = group_hi - group_lo;
                clear_group();
                if (spread < spread_limit)
                begin
                    produced              = 1'b1;
                    report.status         = STATUS_SETTLED;
                    report.mean_value     = mean;
                    report.settle_time_ms = elapsed;
                    running               = 1'b0;
                end
                else if (elapsed > timeout_limit)
                begin
                    produced              = 1'b1;
                    report.status         = STATUS_TIMEOUT;
                    report.mean_value     = mean;
                    report.settle_time_ms = timeout_limit;
                    running               = 1'b0;
                end
            end
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n && (!in_valid || in_ready))
        begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                in_valid <= 1'b1;
                in_data  <= pending_items.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end

    // monitor
    always @(posedge clk)
    begin : monitor
        bit        in_effect;
        bit        has_report;
        out_item_t report;
        out_item_t wanted;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                apply_setting(cfg_index, cfg_data);
                cfg_count++;
            end
            if (in_valid && in_ready)
            begin
                advance_session(in_data, in_effect, has_report, report);
                accepted_count++;
                if (in_effect)
                    effective_count++;
                if (has_report)
                    expected_reports.push_back(report);
            end
            if (out_valid && out_ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, out_data);
                    error_count++;
                end
                else
                begin
                    wanted = expected_reports.pop_front();
                    if (out_data.status !== wanted.status)
                    begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, wanted.status, out_data.status);
                        error_count++;
                    end
                    if (out_data.mean_value !== wanted.mean_value)
                    begin
                        $display("%0t: mean_value mismatch, expected %0d, actual %0d",
                                 $time, wanted.mean_value, out_data.mean_value);
                        error_count++;
                    end
                    if (out_data.settle_time_ms !== wanted.settle_time_ms)
                    begin
                        $display("%0t: settle_time_ms mismatch, expected %0d, actual %0d",
                                 $time, wanted.settle_time_ms, out_data.settle_time_ms);
                        error_count++;
                    end
                    if (wanted.status == STATUS_SETTLED)
                        settled_count++;
                    else
                        timeout_count++;
                end
            end
        end
    end

    task automatic push_item(input logic [OP_W-1:0] op, input logic [SAMPLE_W-1:0] sample);
        in_item_t item;
        item.op     = op;
        item.sample = sample;
        pending_items.push_back(item);
        pushed_count++;
    endtask

    task automatic push_ticks(input int count);
        for (int k = 0; k < count; k++)
            push_item(OP_TICK, SAMPLE_W'($urandom));
    endtask

    task automatic push_group(input int base, input int jitter);
        int value;
        for (int k = 0; k < GROUP_N; k++)
        begin
            if ($urandom_range(0, 3) == 0)
                push_ticks($urandom_range(1, 3));
            value = base + $urandom_range(0, jitter);
            if (value > 4095)
                value = 4095;
            push_item(OP_SAMPLE, SAMPLE_W'(value));
        end
    endtask

    // mostly well-formed sessions; some lack a start or carry stray transactions
    task automatic push_session();
        int groups;
        int jitter;
        groups = $urandom_range(1, 8);
        if ($urandom_range(0, 9) != 0)
            push_item(OP_START, SAMPLE_W'($urandom));
        for (int g = 0; g < groups; g++)
        begin
            case ($urandom_range(0, 3))
                0: jitter = 0;
                1: jitter = $urandom_range(0, spread_choice + 1);
                2: jitter = $urandom_range(0, 63);
                default: jitter = $urandom_range(0, 4095);
            endcase
            push_group($urandom_range(0, 4095), jitter);
            if ($urandom_range(0, 7) == 0)
                push_item(OP_W'($urandom), SAMPLE_W'($urandom));
        end
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || in_valid || expected_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // caller lowers cfg_valid after its last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic load_settings(input logic [SPREAD_W-1:0] spread,
                                 input logic [TIME_W-1:0] limit);
        spread_choice = int'(spread);
        write_reg(CFG_MAX_SPREAD, {4'($urandom), spread});
        write_reg(CFG_TIMEOUT_MS, limit);
        if ($urandom_range(0, 2) == 0)
            write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic load_random_settings();
        logic [SPREAD_W-1:0] spread;
        logic [TIME_W-1:0]   limit;
        case ($urandom_range(0, 4))
            0: spread = '0;
            1: spread = '1;
            2, 3: spread = SPREAD_W'($urandom_range(1, 24));
            default: spread = SPREAD_W'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0: limit = '0;
            1: limit = TIME_MAX;
            2, 3: limit = TIME_W'($urandom_range(1, 40));
            default: limit = TIME_W'($urandom_range(0, 400));
        endcase
        load_settings(spread, limit);
    endtask

    initial
    begin : stimulus
        int phase_start;
        int chunk_start;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        sender_idle_pct   = 21;
        receiver_idle_pct = 74;

        // reset values, session running straight out of reset
        push_ticks(3);
        for (int k = 0; k < GROUP_N; k++)
            push_item(OP_SAMPLE, 12'hFFF);
        push_item(OP_SAMPLE, 12'd7);
        push_item(OP_TICK, '0);
        push_item(OP_UNUSED, 12'hA5A);
        push_item(OP_START, '0);
        push_item(OP_SAMPLE, 12'd1);
        push_item(OP_SAMPLE, 12'd2);
        push_item(OP_START, 12'hFFF);
        push_item(OP_SAMPLE, 12'd10);
        push_item(OP_SAMPLE, 12'd15);
        push_item(OP_SAMPLE, 12'd12);
        push_item(OP_UNUSED, 12'h5A5);
        push_item(OP_SAMPLE, 12'd12);
        push_item(OP_SAMPLE, 12'd11);
        push_item(OP_SAMPLE, 12'd100);
        push_item(OP_SAMPLE, 12'd104);
        push_item(OP_SAMPLE, 12'd102);
        push_item(OP_SAMPLE, 12'd101);
        push_item(OP_SAMPLE, 12'd103);

        // zero spread limit and zero timeout
        wait_idle();
        load_settings('0, '0);
        push_item(OP_START, '0);
        for (int k = 0; k < GROUP_N; k++)
            push_item(OP_SAMPLE, '0);
        push_item(OP_TICK, '0);
        for (int k = 0; k < GROUP_N; k++)
            push_item(OP_SAMPLE, (k % 2 == 0) ? 12'd0 : 12'hFFF);

        for (int phase = 0; phase < 3; phase++)
        begin
            wait_idle();
            sender_idle_pct   = (phase == 0) ? 21 : (phase == 1) ? 74 : 0;
            receiver_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 21 : 0;
            if (phase == 2)
            begin
                // the largest timeout with a zero spread limit, then the largest spread limit
                load_settings('0, TIME_MAX);
                push_item(OP_START, '0);
                for (int k = 0; k < GROUP_N; k++)
                    push_item(OP_SAMPLE, 12'd200);
                wait_idle();
                load_settings('1, TIME_MAX - TIME_W'(1));
                push_item(OP_SAMPLE, 12'd0);
                push_item(OP_SAMPLE, 12'hFFF);
                push_item(OP_SAMPLE, 12'd0);
                push_item(OP_SAMPLE, 12'hFFF);
                push_item(OP_SAMPLE, 12'hFFF);
            end
            phase_start = pushed_count;
            while (pushed_count - phase_start < PHASE_ITEMS)
            begin
                wait_idle();
                load_random_settings();
                chunk_start = pushed_count;
                while (pushed_count - chunk_start < CHUNK_ITEMS)
                begin
                    push_session();
                    while (pending_items.size() > 16)
                        @(posedge clk);
                end
            end
        end

        wait_idle();
        $display("Run covered %0d input transactions (%0d in effect) and %0d config writes.",
                 accepted_count, effective_count, cfg_count);
        $display("Results checked: %0d settled, %0d timed out, %0d mismatches.",
                 settled_count, timeout_count, error_count);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Run timed out.");
        $display("TB_ERROR");
        $finish;
    end

endmodule
